[hdl/lva_pkg.sv]
`default_nettype none
package lva_pkg;

  localparam int OFF_W      = 10;
  localparam int TGT_W      = 34;
  localparam int PASS_W     = 10;
  localparam int MAX_PASSES = 1000;

  typedef logic [31:0] set_t;

  typedef struct packed {
    logic       cf;
    logic [2:0] op;
  } kind_t;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    kind_t            kind;
    logic [3:0]       len;
    logic [31:0]      disp;
  } info_t;

  typedef struct packed {
    logic done;
    logic found;
  } srch_sts_t;

  localparam set_t ALL_SET  = 32'hFFFF_FFFF;
  localparam set_t EXIT_SET = 32'h0000_F039;
  localparam set_t CALL_USE = 32'h0000_03C6;
  localparam set_t CALL_DEF = 32'h0001_0FC7;
  localparam set_t RET_USE  = 32'h0000_F039;
  localparam set_t SYS_USE  = 32'h0000_07C5;
  localparam set_t SYS_DEF  = 32'h0001_0803;

  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_OTHER   = 3'd1;
  localparam logic [2:0] OP_CALL    = 3'd2;
  localparam logic [2:0] OP_RET     = 3'd3;
  localparam logic [2:0] OP_SYSCALL = 3'd4;
  localparam logic [2:0] OP_JCC     = 3'd5;
  localparam logic [2:0] OP_LOOP    = 3'd6;
  localparam logic [2:0] OP_RSVD    = 3'd7;

endpackage
`default_nettype wire

[hdl/lva_decode.sv]
`default_nettype none
module lva_decode (
  input  logic          insn_valid,
  input  logic [2:0]    op_class,
  input  logic [15:0]   read_mask,
  input  logic [15:0]   write_mask,
  input  logic          flags_read,
  input  logic          flags_written,
  input  logic          control_flow,
  output lva_pkg::set_t use_set,
  output lva_pkg::set_t def_set,
  output lva_pkg::kind_t kind
);
  import lva_pkg::*;

  always_comb begin
    use_set   = ALL_SET;
    def_set   = ALL_SET;
    kind.cf   = control_flow;
    kind.op   = op_class;
    if (insn_valid && op_class != OP_NONE) begin
      use_set = {15'd0, flags_read, read_mask};
      def_set = {15'd0, flags_written, write_mask};
      if (op_class == OP_CALL) begin
        use_set = use_set | CALL_USE;
        def_set = def_set | CALL_DEF;
      end
      if (op_class == OP_RET) begin
        use_set = use_set | RET_USE;
      end
      if (op_class == OP_SYSCALL) begin
        use_set = use_set | SYS_USE;
        def_set = def_set | SYS_DEF;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/lva_search.sv]
`default_nettype none
module lva_search #(
  parameter int MAX_INSNS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [$clog2(MAX_INSNS)-1:0]      wr_addr,
  input  logic [lva_pkg::OFF_W-1:0]         wr_off,
  input  logic                              start,
  input  logic signed [lva_pkg::TGT_W-1:0]  tgt,
  input  logic [$clog2(MAX_INSNS+1)-1:0]    n,
  output lva_pkg::srch_sts_t                sts,
  output logic [$clog2(MAX_INSNS)-1:0]      hit_idx
);
  import lva_pkg::*;

  localparam int IW = $clog2(MAX_INSNS);
  localparam int CW = $clog2(MAX_INSNS + 1);

  logic [OFF_W-1:0]        off_mem [MAX_INSNS];
  logic [OFF_W-1:0]        off_rd_r;
  logic                    busy_r;
  logic                    chk_r;
  logic [CW-1:0]           j_r;
  logic [IW-1:0]           jd_r;
  logic signed [TGT_W-1:0] tgt_r;
  srch_sts_t               sts_r;
  logic [IW-1:0]           hit_r;
  logic                    match;

  assign match   = tgt_r == $signed({{(TGT_W-OFF_W){1'b0}}, off_rd_r});
  assign sts     = sts_r;
  assign hit_idx = hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      off_mem[wr_addr] <= wr_off;
    end
    off_rd_r <= off_mem[j_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      sts_r  <= '0;
    end else begin
      sts_r <= '0;
      if (start) begin
        busy_r <= 1'b1;
        chk_r  <= 1'b0;
        j_r    <= '0;
        tgt_r  <= tgt;
      end else if (busy_r) begin
        chk_r <= (j_r < n);
        jd_r  <= j_r[IW-1:0];
        if (j_r < n) begin
          j_r <= j_r + CW'(1);
        end
        if (chk_r) begin
          if (match) begin
            busy_r     <= 1'b0;
            chk_r      <= 1'b0;
            sts_r.done <= 1'b1;
            sts_r.found <= 1'b1;
            hit_r      <= jd_r;
          end else if (CW'(jd_r) == n - CW'(1)) begin
            busy_r     <= 1'b0;
            chk_r      <= 1'b0;
            sts_r.done <= 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[hdl/register_liveness_cfg.sv]
// Register liveness analyzer for a short decoded x86 program.
// Input channel (in_*): one beat per instruction, taken one per cycle while
// loading. The beat with in_last_insn set closes the program and starts the
// analysis; beats past MAX_INSNS are dropped but a last marker still counts.
// in_stall stays high from then until the last result is taken.
// Output channel (out_*): one beat per stored instruction, in index order,
// out_last_result on the final one. A beat holds while out_stall is high.
// Steps after the last input beat, in order:
//   leader scan of every instruction, with a target search for each
//   direct branch (one offset compare per cycle in the target search unit);
//   block split, ending with the close of the last block;
//   liveness passes over the blocks and their instructions; the
//   passes repeat until nothing changes (at most 1000);
//   output of the result beats.
// All stores are memories with registered reads and separate read and write
// addresses; the sequencer steps through them state by state.
// Reset (rst_n low, synchronous) empties the program, clears the leader and
// live-in valid flags and drops any pending result.
`default_nettype none
module register_liveness_cfg #(
  parameter int MAX_INSNS   = 64,
  parameter int BLOCK_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_insn_valid,
  input  logic [2:0]  in_op_class,
  input  logic [15:0] in_read_mask,
  input  logic [15:0] in_write_mask,
  input  logic        in_flags_read,
  input  logic        in_flags_written,
  input  logic        in_control_flow,
  input  logic [3:0]  in_insn_length,
  input  logic signed [31:0] in_target_disp,
  input  logic        in_last_insn,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_insn_index,
  output logic [31:0] out_use_set,
  output logic [31:0] out_def_set,
  output logic [31:0] out_live_in_set,
  output logic [31:0] out_live_out_set,
  output logic [6:0]  out_block_total,
  output logic        out_last_result
);
  import lva_pkg::*;

  localparam int IW  = $clog2(MAX_INSNS);
  localparam int CW  = $clog2(MAX_INSNS + 1);
  localparam int BW  = (BLOCK_LIMIT > 1) ? $clog2(BLOCK_LIMIT) : 1;
  localparam int NBW = $clog2(BLOCK_LIMIT + 1);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_L0   = 4'd1;
  localparam logic [3:0] S_L1   = 4'd2;
  localparam logic [3:0] S_L2   = 4'd3;
  localparam logic [3:0] S_B0   = 4'd4;
  localparam logic [3:0] S_B1   = 4'd5;
  localparam logic [3:0] S_BF   = 4'd6;
  localparam logic [3:0] S_P0   = 4'd7;
  localparam logic [3:0] S_P1   = 4'd8;
  localparam logic [3:0] S_P2   = 4'd9;
  localparam logic [3:0] S_P3   = 4'd10;
  localparam logic [3:0] S_I0   = 4'd11;
  localparam logic [3:0] S_I1   = 4'd12;
  localparam logic [3:0] S_O0   = 4'd13;
  localparam logic [3:0] S_O1   = 4'd14;
  localparam logic [3:0] S_O2   = 4'd15;

  logic [3:0]           state_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        n_r;
  logic [OFF_W-1:0]     roff_r;
  logic [IW-1:0]        i_r;
  logic [IW-1:0]        s_r;
  logic [IW-1:0]        e_r;
  logic [IW-1:0]        cur_s_r;
  logic [NBW-1:0]       nb_r;
  logic [BW-1:0]        b_r;
  logic [PASS_W-1:0]    pass_r;
  logic                 changed_r;
  logic                 prev_ret_r;
  logic                 nxt_ok_r;
  set_t                 nout_r;
  set_t                 live_r;
  logic [MAX_INSNS-1:0] lead_r;
  logic [MAX_INSNS-1:0] lin_vld_r;
  logic                 out_valid_r;

  set_t                 use_mem   [MAX_INSNS];
  set_t                 def_mem   [MAX_INSNS];
  info_t                info_mem  [MAX_INSNS];
  logic [IW:0]          tgt_mem   [MAX_INSNS];
  set_t                 lin_mem   [MAX_INSNS];
  set_t                 lout_mem  [MAX_INSNS];
  logic [2*IW-1:0]      blk_mem   [BLOCK_LIMIT];
  set_t                 bexit_mem [BLOCK_LIMIT];

  set_t                 use_rd_r;
  set_t                 def_rd_r;
  info_t                info_rd_r;
  logic [IW:0]          tgt_rd_r;
  set_t                 lin_rd_r;
  logic                 lin_v_rd_r;
  set_t                 lout_rd_r;
  logic [2*IW-1:0]      blk_rd_r;
  set_t                 bexit_rd_r;

  set_t                 dec_use;
  set_t                 dec_def;
  kind_t                dec_kind;
  logic                 acc_in;
  logic                 store_en;
  logic [IW-1:0]        n_m1;
  logic [IW-1:0]        i_p1;
  logic [IW-1:0]        blk_s;
  logic [IW-1:0]        blk_e;
  logic [CW-1:0]        e_p1;
  logic [BW-1:0]        nb_m1;
  logic [NBW-1:0]       nb_inc;
  logic [IW-1:0]        info_ra;
  logic [IW-1:0]        tgt_ra;
  logic [IW-1:0]        lin_ra;
  set_t                 lin_val;
  set_t                 nout_p3;
  set_t                 live_new;
  logic                 cf_i;
  logic                 disp_nz;
  logic                 tgt_we;
  logic [IW:0]          tgt_wd;
  logic                 blk_we;
  logic [2*IW-1:0]      blk_wd;
  logic                 bexit_we;
  logic [BW-1:0]        bexit_wa;
  set_t                 bexit_wd;
  logic                 srch_start;
  logic signed [TGT_W-1:0] tgt_val;
  srch_sts_t            srch_sts;
  logic [IW-1:0]        srch_hit;

  lva_decode u_decode (
    .insn_valid    (in_insn_valid),
    .op_class      (in_op_class),
    .read_mask     (in_read_mask),
    .write_mask    (in_write_mask),
    .flags_read    (in_flags_read),
    .flags_written (in_flags_written),
    .control_flow  (in_control_flow),
    .use_set       (dec_use),
    .def_set       (dec_def),
    .kind          (dec_kind)
  );

  lva_search #(.MAX_INSNS(MAX_INSNS)) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (store_en),
    .wr_addr (cnt_r[IW-1:0]),
    .wr_off  (roff_r),
    .start   (srch_start),
    .tgt     (tgt_val),
    .n       (n_r),
    .sts     (srch_sts),
    .hit_idx (srch_hit)
  );

  assign in_stall = (state_r != S_LOAD);
  assign acc_in   = in_valid && !in_stall;
  assign store_en = acc_in && (cnt_r < CW'(MAX_INSNS));

  assign n_m1     = IW'(n_r - CW'(1));
  assign i_p1     = i_r + IW'(1);
  assign blk_s    = blk_rd_r[2*IW-1:IW];
  assign blk_e    = blk_rd_r[IW-1:0];
  assign e_p1     = CW'(blk_e) + CW'(1);
  assign nb_m1    = BW'(nb_r - NBW'(1));
  assign nb_inc   = nb_r + NBW'(lead_r[i_r]);
  assign lin_val  = lin_v_rd_r ? lin_rd_r : '0;
  assign cf_i     = info_rd_r.kind.cf;
  assign disp_nz  = info_rd_r.disp != 32'd0;
  assign tgt_val  = $signed({24'd0, info_rd_r.off}) + $signed({30'd0, info_rd_r.len})
                  + $signed({{2{info_rd_r.disp[31]}}, info_rd_r.disp});
  assign nout_p3  = (info_rd_r.kind.op == OP_RET) ? EXIT_SET
                  : (nout_r | (tgt_rd_r[IW] ? lin_val : '0));
  assign live_new = use_rd_r | (live_r & ~def_rd_r);

  always_comb begin
    info_ra = e_r;
    tgt_ra  = e_r;
    lin_ra  = i_r;
    if (state_r == S_L0 || state_r == S_B0) begin
      info_ra = i_r;
    end
    if (state_r == S_P1) begin
      info_ra = blk_e;
      tgt_ra  = blk_e;
      lin_ra  = e_p1[IW-1:0];
    end
    if (state_r == S_P2) begin
      lin_ra = tgt_rd_r[IW-1:0];
    end
  end

  always_comb begin
    tgt_we     = 1'b0;
    tgt_wd     = '0;
    srch_start = 1'b0;
    blk_we     = 1'b0;
    blk_wd     = {cur_s_r, n_m1};
    bexit_we   = 1'b0;
    bexit_wa   = nb_m1;
    bexit_wd   = EXIT_SET;
    if (state_r == S_L1) begin
      if (cf_i && disp_nz) begin
        srch_start = 1'b1;
      end else begin
        tgt_we = 1'b1;
      end
    end
    if (state_r == S_L2 && srch_sts.done) begin
      tgt_we = 1'b1;
      tgt_wd = {srch_sts.found, srch_hit};
    end
    if (state_r == S_B1 && lead_r[i_r] && nb_r != '0) begin
      blk_we   = 1'b1;
      blk_wd   = {cur_s_r, i_r - IW'(1)};
      bexit_we = 1'b1;
      bexit_wd = prev_ret_r ? EXIT_SET : ALL_SET;
    end
    if (state_r == S_BF) begin
      blk_we   = 1'b1;
      bexit_we = 1'b1;
    end
    if (state_r == S_P3) begin
      bexit_we = 1'b1;
      bexit_wa = b_r;
      bexit_wd = nout_p3;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      use_mem[cnt_r[IW-1:0]]  <= dec_use;
      def_mem[cnt_r[IW-1:0]]  <= dec_def;
      info_mem[cnt_r[IW-1:0]] <= '{off: roff_r, kind: dec_kind, len: in_insn_length,
                                   disp: in_target_disp};
    end
    use_rd_r  <= use_mem[i_r];
    def_rd_r  <= def_mem[i_r];
    info_rd_r <= info_mem[info_ra];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[i_r] <= tgt_wd;
    end
    tgt_rd_r <= tgt_mem[tgt_ra];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_I1) begin
      lin_mem[i_r]  <= live_new;
      lout_mem[i_r] <= live_r;
    end
    lin_rd_r   <= lin_mem[lin_ra];
    lin_v_rd_r <= lin_vld_r[lin_ra];
    lout_rd_r  <= lout_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[nb_m1] <= blk_wd;
    end
    if (bexit_we) begin
      bexit_mem[bexit_wa] <= bexit_wd;
    end
    blk_rd_r   <= blk_mem[b_r];
    bexit_rd_r <= bexit_mem[b_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      roff_r      <= '0;
      lead_r      <= '0;
      lin_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (acc_in) begin
            if (store_en) begin
              cnt_r  <= cnt_r + CW'(1);
              roff_r <= roff_r + OFF_W'(in_insn_length);
            end
            if (in_last_insn) begin
              state_r   <= S_L0;
              i_r       <= '0;
              n_r       <= store_en ? cnt_r + CW'(1) : cnt_r;
              lead_r    <= MAX_INSNS'(1);
              lin_vld_r <= '0;
            end
          end
        end
        S_L0: state_r <= S_L1;
        S_L1: begin
          if (cf_i && (CW'(i_r) + CW'(1) < n_r)) begin
            lead_r[i_p1] <= 1'b1;
          end
          if (cf_i && disp_nz) begin
            state_r <= S_L2;
          end else if (i_r == n_m1) begin
            state_r    <= S_B0;
            i_r        <= '0;
            nb_r       <= '0;
            prev_ret_r <= 1'b0;
          end else begin
            i_r     <= i_p1;
            state_r <= S_L0;
          end
        end
        S_L2: begin
          if (srch_sts.done) begin
            if (srch_sts.found) begin
              lead_r[srch_hit] <= 1'b1;
            end
            if (i_r == n_m1) begin
              state_r    <= S_B0;
              i_r        <= '0;
              nb_r       <= '0;
              prev_ret_r <= 1'b0;
            end else begin
              i_r     <= i_p1;
              state_r <= S_L0;
            end
          end
        end
        S_B0: state_r <= S_B1;
        S_B1: begin
          prev_ret_r <= (info_rd_r.kind.op == OP_RET);
          if (lead_r[i_r]) begin
            cur_s_r <= i_r;
          end
          nb_r <= nb_inc;
          if (i_r == n_m1 || nb_inc == NBW'(BLOCK_LIMIT)) begin
            state_r <= S_BF;
          end else begin
            i_r     <= i_p1;
            state_r <= S_B0;
          end
        end
        S_BF: begin
          b_r       <= nb_m1;
          pass_r    <= '0;
          changed_r <= 1'b0;
          state_r   <= S_P0;
        end
        S_P0: state_r <= S_P1;
        S_P1: begin
          s_r      <= blk_s;
          e_r      <= blk_e;
          nxt_ok_r <= e_p1 < n_r;
          state_r  <= S_P2;
        end
        S_P2: begin
          if (nxt_ok_r && (!cf_i || info_rd_r.kind.op == OP_JCC
                           || info_rd_r.kind.op == OP_LOOP
                           || info_rd_r.kind.op == OP_CALL)) begin
            nout_r <= lin_val;
          end else begin
            nout_r <= '0;
          end
          state_r <= S_P3;
        end
        S_P3: begin
          if (nout_p3 != bexit_rd_r) begin
            changed_r <= 1'b1;
          end
          live_r  <= nout_p3;
          i_r     <= e_r;
          state_r <= S_I0;
        end
        S_I0: state_r <= S_I1;
        S_I1: begin
          live_r         <= live_new;
          lin_vld_r[i_r] <= 1'b1;
          if (i_r == s_r) begin
            if (b_r == '0) begin
              if (!changed_r || pass_r == PASS_W'(MAX_PASSES - 1)) begin
                i_r     <= '0;
                state_r <= S_O0;
              end else begin
                pass_r    <= pass_r + PASS_W'(1);
                changed_r <= 1'b0;
                b_r       <= nb_m1;
                state_r   <= S_P0;
              end
            end else begin
              b_r     <= b_r - BW'(1);
              state_r <= S_P0;
            end
          end else begin
            i_r     <= i_r - IW'(1);
            state_r <= S_I0;
          end
        end
        S_O0: state_r <= S_O1;
        S_O1: begin
          out_insn_index   <= 6'(i_r);
          out_use_set      <= use_rd_r;
          out_def_set      <= def_rd_r;
          out_live_in_set  <= lin_val;
          out_live_out_set <= lout_rd_r;
          out_block_total  <= 7'(nb_r);
          out_last_result  <= (i_r == n_m1);
          out_valid_r      <= 1'b1;
          state_r          <= S_O2;
        end
        S_O2: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (i_r == n_m1) begin
              cnt_r   <= '0;
              roff_r  <= '0;
              state_r <= S_LOAD;
            end else begin
              i_r     <= i_p1;
              state_r <= S_O0;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  a_beat_only_when_presenting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_O2)
    else $error("result beat shown outside the output state");

  a_first_is_leader: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> lead_r[0])
    else $error("instruction zero lost its leader mark");

  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_I1) |-> pass_r < PASS_W'(MAX_PASSES))
    else $error("liveness pass count past its bound");

  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_result) |=> state_r == S_LOAD)
    else $error("not back to loading after the final result");

endmodule
`default_nettype wire

[test/tb_register_liveness_cfg.sv]
`timescale 1ns / 1ps

module tb_register_liveness_cfg;
  import lva_pkg::*;

  typedef struct {
    bit        iv;
    bit [2:0]  op;
    bit [15:0] rmask;
    bit [15:0] wmask;
    bit        fr;
    bit        fw;
    bit        cf;
    bit [3:0]  len;
    bit [31:0] disp;
    bit        last;
  } insn_t;

  typedef struct {
    bit [5:0]  idx;
    bit [31:0] use_s;
    bit [31:0] def_s;
    bit [31:0] lin;
    bit [31:0] lout;
    bit [6:0]  nblk;
    bit        last;
  } live_res_t;

  class liveness_sb;
    bit [31:0] use_m[64], def_m[64], lin_m[64], lout_m[64], disp_m[64];
    int        off_m[64], len_m[64], bstart[64], blen[64];
    bit [2:0]  op_m[64];
    bit        cf_m[64], leader[64];
    bit [31:0] bexit[64];
    int        ninsn, roff, errors, programs, results;
    live_res_t expq[$];

    function new();
      ninsn = 0; roff = 0; errors = 0; programs = 0; results = 0;
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    function int target_of(int k, int n);
      longint t;
      t = longint'(off_m[k]) + longint'(len_m[k]) + longint'($signed(disp_m[k]));
      for (int j = 0; j < n; j++) if (longint'(off_m[j]) == t) return j;
      return -1;
    endfunction

    function int run_liveness(int n);
      int nb, e, s, t;
      bit changed, cf;
      bit [2:0] op;
      bit [31:0] nout, lv;
      nb = 0;
      for (int i = 0; i < 64; i++) begin
        lin_m[i] = 0; leader[i] = 0;
      end
      leader[0] = 1;
      for (int i = 0; i < n; i++) begin
        if (cf_m[i]) begin
          if (i + 1 < n) leader[i+1] = 1;
          if (disp_m[i] != 0) begin
            t = target_of(i, n);
            if (t >= 0) leader[t] = 1;
          end
        end
      end
      for (int i = 0; i < n && nb < 64; i++) begin
        if (leader[i]) begin
          if (nb > 0) blen[nb-1] = i - bstart[nb-1];
          bstart[nb] = i; nb++;
        end
      end
      blen[nb-1] = n - bstart[nb-1];
      for (int b = 0; b < nb; b++) begin
        e = bstart[b] + blen[b] - 1;
        bexit[b] = (e == n - 1 || op_m[e] == OP_RET) ? EXIT_SET : ALL_SET;
      end
      for (int p = 0; p < MAX_PASSES; p++) begin
        changed = 0;
        for (int b = nb - 1; b >= 0; b--) begin
          s = bstart[b]; e = s + blen[b] - 1;
          op = op_m[e]; cf = cf_m[e]; nout = 0;
          if (e + 1 < n && (!cf || op == OP_JCC || op == OP_LOOP || op == OP_CALL))
            nout |= lin_m[e+1];
          if (cf && disp_m[e] != 0) begin
            t = target_of(e, n);
            if (t >= 0) nout |= lin_m[t];
          end
          if (op == OP_RET) nout = EXIT_SET;
          if (nout != bexit[b]) begin
            bexit[b] = nout; changed = 1;
          end
          lv = bexit[b];
          for (int i = e; i >= s; i--) begin
            lout_m[i] = lv;
            lv = use_m[i] | (lv & ~def_m[i]);
            lin_m[i] = lv;
          end
        end
        if (!changed) break;
      end
      return nb;
    endfunction

    function void note_insn(insn_t x);
      bit [31:0] u, d;
      int nb;
      live_res_t r;
      if (ninsn < 64) begin
        if (!x.iv || x.op == OP_NONE) begin
          u = ALL_SET; d = ALL_SET;
        end else begin
          u = {15'b0, x.fr, x.rmask};
          d = {15'b0, x.fw, x.wmask};
          if (x.op == OP_CALL) begin
            u |= CALL_USE; d |= CALL_DEF;
          end
          if (x.op == OP_RET) u |= RET_USE;
          if (x.op == OP_SYSCALL) begin
            u |= SYS_USE; d |= SYS_DEF;
          end
        end
        use_m[ninsn] = u; def_m[ninsn] = d; off_m[ninsn] = roff;
        op_m[ninsn] = x.op; cf_m[ninsn] = x.cf; disp_m[ninsn] = x.disp;
        len_m[ninsn] = int'(x.len);
        roff = (roff + int'(x.len)) % 1024;
        ninsn++;
      end
      if (!x.last || ninsn == 0) return;
      nb = run_liveness(ninsn);
      for (int i = 0; i < ninsn; i++) begin
        r.idx = 6'(i); r.use_s = use_m[i]; r.def_s = def_m[i];
        r.lin = lin_m[i]; r.lout = lout_m[i]; r.nblk = 7'(nb);
        r.last = (i + 1 == ninsn);
        expq.push_back(r);
      end
      programs++;
      ninsn = 0; roff = 0;
    endfunction

    task check_result(live_res_t g);
      live_res_t w;
      if (expq.size() == 0) begin
        report("unexpected result beat, insn_index", int'(g.idx), 0);
        return;
      end
      w = expq.pop_front();
      results++;
      if (g.idx != w.idx) report("insn_index", g.idx, w.idx);
      if (g.use_s != w.use_s) report("use_set", g.use_s, w.use_s);
      if (g.def_s != w.def_s) report("def_set", g.def_s, w.def_s);
      if (g.lin != w.lin) report("live_in_set", g.lin, w.lin);
      if (g.lout != w.lout) report("live_out_set", g.lout, w.lout);
      if (g.nblk != w.nblk) report("block_total", g.nblk, w.nblk);
      if (g.last != w.last) report("last_result", g.last, w.last);
    endtask
  endclass

  localparam int IDLE_LIMIT = 2000000;

  logic        clk = 0, rst_n = 0;
  logic        in_valid = 0, in_stall;
  logic        in_insn_valid = 0, in_flags_read = 0, in_flags_written = 0;
  logic        in_control_flow = 0, in_last_insn = 0;
  logic [2:0]  in_op_class = 0;
  logic [15:0] in_read_mask = 0, in_write_mask = 0;
  logic [3:0]  in_insn_length = 1;
  logic signed [31:0] in_target_disp = 0;
  logic        out_valid, out_stall = 1;
  logic [5:0]  out_insn_index;
  logic [31:0] out_use_set, out_def_set, out_live_in_set, out_live_out_set;
  logic [6:0]  out_block_total;
  logic        out_last_result;

  liveness_sb sb = new();
  int  hold_cycles = 0;
  bit  steady = 0;
  int  idle = 0;
  int  sent = 0;
  insn_t prog[$];

  register_liveness_cfg dut (.*);

  always #4 clk = ~clk;

  function int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (steady || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= steady ? 1'b0 : (gap_len() != 0);
    end
  end

  always @(posedge clk) begin
    live_res_t g;
    if (rst_n && out_valid && !out_stall) begin
      g.idx = out_insn_index; g.use_s = out_use_set; g.def_s = out_def_set;
      g.lin = out_live_in_set; g.lout = out_live_out_set;
      g.nblk = out_block_total; g.last = out_last_result;
      sb.check_result(g);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle <= 0;
    else idle <= idle + 1;
    if (idle > IDLE_LIMIT) begin
      $display("[register_liveness_cfg] ERROR");
      $finish;
    end
  end

  task send_insn(insn_t x);
    int g;
    @(negedge clk);
    in_valid <= 1; in_insn_valid <= x.iv; in_op_class <= x.op;
    in_read_mask <= x.rmask; in_write_mask <= x.wmask;
    in_flags_read <= x.fr; in_flags_written <= x.fw;
    in_control_flow <= x.cf; in_insn_length <= x.len;
    in_target_disp <= x.disp; in_last_insn <= x.last;
    do @(posedge clk); while (in_stall);
    sb.note_insn(x);
    sent++;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // n instructions, branches aimed mostly at real instruction boundaries, or no displacements when all_cf is set
  task build_program(int n, bit all_cf);
    int offs[$];
    int o, j;
    insn_t x;
    prog.delete();
    o = 0;
    for (int k = 0; k < n; k++) begin
      x.iv = ($urandom_range(0, 15) != 0);
      x.op = 3'($urandom_range(0, 7));
      x.rmask = 16'($urandom); x.wmask = 16'($urandom);
      if ($urandom_range(0, 1)) x.rmask &= 16'($urandom);
      if ($urandom_range(0, 1)) x.wmask &= 16'($urandom);
      x.fr = 1'($urandom); x.fw = 1'($urandom);
      x.cf = all_cf || ((x.op >= OP_CALL && x.op <= OP_LOOP) ? ($urandom_range(0, 7) != 0)
                                                             : ($urandom_range(0, 7) == 0));
      x.len = 4'($urandom_range(1, 15));
      x.disp = 0;
      offs.push_back(o);
      prog.push_back(x);
      o += int'(x.len);
    end
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 7))
        0: prog[k].disp = 0;
        7: prog[k].disp = $urandom;
        default: begin
          j = $urandom_range(0, n - 1);
          prog[k].disp = offs[j] - (offs[k] + int'(prog[k].len));
        end
      endcase
      if (all_cf) prog[k].disp = 0;
      prog[k].last = (k == n - 1);
    end
  endtask

  task send_program();
    foreach (prog[k]) send_insn(prog[k]);
  endtask

  function insn_t mk(bit iv, bit [2:0] op, bit [15:0] rm, bit [15:0] wm, bit fr, bit fw,
                     bit cf, bit [3:0] len, bit [31:0] disp, bit last);
    insn_t x;
    x.iv = iv; x.op = op; x.rmask = rm; x.wmask = wm; x.fr = fr; x.fw = fw;
    x.cf = cf; x.len = len; x.disp = disp; x.last = last;
    return x;
  endfunction

  initial begin
    int n;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed program: every op class, barriers, field extremes, branch corners
    prog.delete();
    prog.push_back(mk(1, OP_OTHER, 16'hFFFF, 16'hFFFF, 1, 1, 0, 4'd1, 0, 0));
    prog.push_back(mk(1, OP_OTHER, 16'h0000, 16'h0000, 0, 0, 0, 4'd15, 0, 0));
    prog.push_back(mk(0, OP_OTHER, 16'h00F0, 16'h0F00, 1, 0, 0, 4'd2, 0, 0));
    prog.push_back(mk(1, OP_NONE, 16'h0001, 16'h0002, 0, 1, 0, 4'd3, 0, 0));
    prog.push_back(mk(1, OP_RSVD, 16'h8001, 16'h0004, 1, 1, 0, 4'd4, 0, 0));
    prog.push_back(mk(1, OP_CALL, 16'h0000, 16'h0000, 0, 0, 1, 4'd5, 32'd8, 0));
    prog.push_back(mk(1, OP_SYSCALL, 16'h0010, 16'h0020, 0, 0, 0, 4'd2, 0, 0));
    prog.push_back(mk(1, OP_JCC, 16'h0000, 16'h0000, 1, 0, 1, 4'd2, -32'sd14, 0));
    prog.push_back(mk(1, OP_LOOP, 16'h0002, 16'h0002, 0, 0, 1, 4'd2, -32'sd4, 0));
    prog.push_back(mk(1, OP_JCC, 16'h0000, 16'h0000, 1, 0, 1, 4'd6, 32'h8000_0000, 0));
    prog.push_back(mk(1, OP_JCC, 16'h0000, 16'h0000, 1, 0, 1, 4'd6, 32'h7FFF_FFFF, 0));
    prog.push_back(mk(1, OP_OTHER, 16'h00FF, 16'hFF00, 0, 1, 1, 4'd8, 32'd3, 0));
    prog.push_back(mk(1, OP_RET, 16'h0000, 16'h0000, 0, 0, 1, 4'd1, 0, 0));
    prog.push_back(mk(1, OP_OTHER, 16'h0F0F, 16'hF0F0, 1, 1, 0, 4'd7, 0, 1));
    send_program();
    prog.delete();
    prog.push_back(mk(1, OP_RET, 16'h0000, 16'h0000, 0, 0, 1, 4'd1, 0, 1));
    send_program();

    // long receiver hold while the next programs are offered
    hold_cycles = 3000;
    build_program(64, 1);
    send_program();
    // overflow: last marker arrives on a dropped beat
    build_program(66, 0);
    prog[63].last = 0;
    send_program();

    while (sent < 150) begin
      steady = ($urandom_range(0, 5) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 10);
      build_program(n, 0);
      send_program();
    end
    steady = 0;

    @(negedge clk);
    in_valid <= 0;
    while (sb.expq.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("ran %0d instruction beats in %0d programs, %0d result beats checked",
             sent, sb.programs, sb.results);
    $display("covered barriers, all op classes, branch targets, block limit and overflow");
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("[register_liveness_cfg] OK");
    end else begin
      $display("[register_liveness_cfg] ERROR");
    end
    $finish;
  end

endmodule

[register_liveness_cfg.f]
hdl/lva_pkg.sv
hdl/lva_decode.sv
hdl/lva_search.sv
hdl/register_liveness_cfg.sv
test/tb_register_liveness_cfg.sv
